// ----- design/gdm_pkg.sv -----
// gdm_pkg: shared types and constants for the generational distance block
// item structs, widths, mode/status codes and the default parameter values
// no dependencies
package gdm_pkg;

   localparam int COORD_W = 24;
   localparam int NUM_COORDS = 8;
   localparam int SQUARE_W = 2 * COORD_W;
   localparam int ACC_W = 52;
   localparam int ROOT_W = ACC_W / 2;
   localparam int DIST_W = 27;
   localparam int SUM_W = 43;
   localparam int DIM_W = 4;

   localparam int DEF_FRONT_DEPTH = 1024;
   localparam int DEF_MAX_DIMENSIONS = 8;
   localparam int DEF_MAX_POPULATION = 65536;

   localparam logic [DIM_W-1:0] DIM_RESET = 4'd2;

   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_LOAD = 2'd1;
   localparam logic [1:0] MODE_MEASURE = 2'd2;
   localparam logic [1:0] MODE_FINISH = 2'd3;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_EMPTY_FRONT = 2'd1;
   localparam logic [1:0] STATUS_NO_POPULATION = 2'd2;
   localparam logic [1:0] STATUS_FRONT_FULL = 2'd3;

   localparam logic KIND_POINT = 1'b0;
   localparam logic KIND_FINAL = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic [1:0] mode;
      logic signed [COORD_W-1:0] coord_0;
      logic signed [COORD_W-1:0] coord_1;
      logic signed [COORD_W-1:0] coord_2;
      logic signed [COORD_W-1:0] coord_3;
      logic signed [COORD_W-1:0] coord_4;
      logic signed [COORD_W-1:0] coord_5;
      logic signed [COORD_W-1:0] coord_6;
      logic signed [COORD_W-1:0] coord_7;
   } gdm_req_type;

   typedef struct packed {
      logic result_kind;
      logic [DIST_W-1:0] distance_value;
      logic [1:0] status;
   } gdm_rsp_type;

endpackage

// ----- design/gdm_lane.sv -----
// gdm_lane: one coordinate lane, registered squared difference
// depends on gdm_pkg
module gdm_lane
   import gdm_pkg::*;
(
   input  logic clock,
   input  logic enable,
   input  coord_type front_coord,
   input  coord_type point_coord,
   output logic [SQUARE_W-1:0] square
);

   logic signed [COORD_W:0] diff;
   logic [COORD_W-1:0] mag;
   logic [SQUARE_W-1:0] square_ff;

   always_comb begin
      diff = {front_coord[COORD_W-1], front_coord} - {point_coord[COORD_W-1], point_coord};
      mag = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      square_ff <= enable ? mag * mag : '0;
   end

   assign square = square_ff;

endmodule

// ----- design/gdm_isqrt.sv -----
// gdm_isqrt: iterative integer square root, two radicand bits per cycle
// depends on gdm_pkg
module gdm_isqrt
   import gdm_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [ACC_W-1:0] radicand,
   output logic done,
   output logic [ROOT_W-1:0] root
);

   localparam int RW = ROOT_W + 2;
   localparam int CNT_W = $clog2(ROOT_W);

   logic [ACC_W-1:0] val_ff;
   logic [RW-1:0] rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic busy_ff, done_ff;
   logic [RW-1:0] rem_next, trial;

   always_comb begin
      rem_next = {rem_ff[RW-3:0], val_ff[ACC_W-1 -: 2]};
      trial = {root_ff, 2'b01};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNT_W'(ROOT_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (start) begin
         val_ff <= radicand;
         rem_ff <= '0;
         root_ff <= '0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         val_ff <= {val_ff[ACC_W-3:0], 2'b00};
         cnt_ff <= cnt_ff + 1'b1;
         if (rem_next >= trial) begin
            rem_ff <= rem_next - trial;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_next;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- design/gdm_div.sv -----
// gdm_div: restoring divider, one quotient bit per cycle
// depends on gdm_pkg
module gdm_div
   import gdm_pkg::*;
#(
   parameter int DEN_W = 17
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [SUM_W-1:0] numerator,
   input  logic [DEN_W-1:0] denominator,
   output logic done,
   output logic [SUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(SUM_W);

   logic [SUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0] rem_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic busy_ff, done_ff;
   logic [DEN_W:0] rem_next;

   assign rem_next = {rem_ff[DEN_W-1:0], num_ff[SUM_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNT_W'(SUM_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (start) begin
         num_ff <= numerator;
         den_ff <= denominator;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (rem_next >= {1'b0, den_ff}) begin
            rem_ff <= rem_next - {1'b0, den_ff};
            num_ff <= {num_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_next;
            num_ff <= {num_ff[SUM_W-2:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign quotient = num_ff;

endmodule

// ----- design/generational_distance_metric.sv -----
// generational distance top level: front store, coordinate lanes, merge, sqrt and divide
// measure scans one stored row per cycle through memory read, lanes and merge, then
// takes 26 root steps; finish runs the divider
// one item at a time; the scan of the front store sets the rate for measured points
// synchronous active-high reset clears counts, sum and control; front store is not cleared
// depends on gdm_pkg, gdm_lane, gdm_isqrt, gdm_div
module generational_distance_metric
   import gdm_pkg::*;
#(
   parameter int FRONT_DEPTH = DEF_FRONT_DEPTH,
   parameter int MAX_DIMENSIONS = DEF_MAX_DIMENSIONS,
   parameter int MAX_POPULATION = DEF_MAX_POPULATION
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  gdm_req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output gdm_rsp_type rsp_data,
   input  logic csr_write_enable,
   input  logic [DIM_W-1:0] csr_write_data
);

   localparam int AW = (FRONT_DEPTH > 1) ? $clog2(FRONT_DEPTH) : 1;
   localparam int CW = $clog2(FRONT_DEPTH + 1);
   localparam int PW = $clog2(MAX_POPULATION + 1);
   localparam int ROW_W = MAX_DIMENSIONS * COORD_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_SQRT = 3'd3;
   localparam logic [2:0] ST_DIV = 3'd4;
   localparam logic [2:0] ST_OUT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [DIM_W-1:0] dim_ff;
   logic [CW-1:0] front_count_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [PW-1:0] pop_ff;
   logic [AW-1:0] scan_addr_ff;
   logic rd_v_ff, sq_v_ff, acc_v_ff, have_ff;
   logic [ROW_W-1:0] front_mem [FRONT_DEPTH];
   logic [ROW_W-1:0] rd_row_ff, row_in;
   coord_type pt_ff [MAX_DIMENSIONS];
   coord_type req_coords [NUM_COORDS];
   logic [SQUARE_W-1:0] lane_sq [MAX_DIMENSIONS];
   logic [MAX_DIMENSIONS-1:0] lane_en;
   logic [DIM_W-1:0] dims_eff;
   logic [ACC_W-1:0] acc_in, acc_ff, best_ff;
   gdm_rsp_type result_ff, result_in;
   logic rsp_valid_ff;
   gdm_rsp_type rsp_data_ff;
   logic accept, out_free, sqrt_start, sqrt_done, div_start, div_done;
   logic [ROOT_W-1:0] root;
   logic [SUM_W-1:0] quotient;

   assign accept = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      req_coords[0] = req_data.coord_0;
      req_coords[1] = req_data.coord_1;
      req_coords[2] = req_data.coord_2;
      req_coords[3] = req_data.coord_3;
      req_coords[4] = req_data.coord_4;
      req_coords[5] = req_data.coord_5;
      req_coords[6] = req_data.coord_6;
      req_coords[7] = req_data.coord_7;
      for (int i = 0; i < MAX_DIMENSIONS; i++) begin
         row_in[i*COORD_W +: COORD_W] = req_coords[i];
      end
      dims_eff = (dim_ff > DIM_W'(MAX_DIMENSIONS)) ? DIM_W'(MAX_DIMENSIONS) : dim_ff;
      for (int i = 0; i < MAX_DIMENSIONS; i++) begin
         lane_en[i] = (DIM_W'(i) < dims_eff);
      end
   end

   // coordinate lanes
   for (genvar g = 0; g < MAX_DIMENSIONS; g++) begin : g_lane
      gdm_lane u_lane (
         .clock(clock),
         .enable(lane_en[g]),
         .front_coord(rd_row_ff[g*COORD_W +: COORD_W]),
         .point_coord(pt_ff[g]),
         .square(lane_sq[g])
      );
   end

   // merge of lane squares
   always_comb begin
      acc_in = '0;
      for (int i = 0; i < MAX_DIMENSIONS; i++) begin
         acc_in = acc_in + ACC_W'(lane_sq[i]);
      end
   end

   gdm_isqrt u_isqrt (
      .clock(clock),
      .reset(reset),
      .start(sqrt_start),
      .radicand(best_ff),
      .done(sqrt_done),
      .root(root)
   );

   gdm_div #(.DEN_W(PW)) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .numerator(sum_ff),
      .denominator(pop_ff),
      .done(div_done),
      .quotient(quotient)
   );

   always_comb begin
      state_in = state_ff;
      result_in = result_ff;
      sqrt_start = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.mode)
                  MODE_CLEAR: state_in = ST_IDLE;
                  MODE_LOAD: begin
                     if (front_count_ff == CW'(FRONT_DEPTH)) begin
                        result_in = '{KIND_FINAL, '0, STATUS_FRONT_FULL};
                        state_in = ST_OUT;
                     end
                  end
                  MODE_MEASURE: begin
                     if (front_count_ff == '0) begin
                        result_in = '{KIND_POINT, '0, STATUS_EMPTY_FRONT};
                        state_in = ST_OUT;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  MODE_FINISH: begin
                     if (front_count_ff == '0) begin
                        result_in = '{KIND_FINAL, '0, STATUS_EMPTY_FRONT};
                        state_in = ST_OUT;
                     end else if (pop_ff == '0) begin
                        result_in = '{KIND_FINAL, '0, STATUS_NO_POPULATION};
                        state_in = ST_OUT;
                     end else begin
                        div_start = 1'b1;
                        state_in = ST_DIV;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (CW'(scan_addr_ff) + 1'b1 == front_count_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_v_ff && !sq_v_ff && !acc_v_ff) begin
               sqrt_start = 1'b1;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               result_in = '{KIND_POINT, DIST_W'(root), STATUS_OK};
               state_in = ST_OUT;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               result_in = '{KIND_FINAL, quotient[DIST_W-1:0], STATUS_OK};
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dim_ff <= DIM_RESET;
         front_count_ff <= '0;
         sum_ff <= '0;
         pop_ff <= '0;
         rd_v_ff <= 1'b0;
         sq_v_ff <= 1'b0;
         acc_v_ff <= 1'b0;
         have_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            dim_ff <= csr_write_data;
         end
         rd_v_ff <= (state_ff == ST_SCAN);
         sq_v_ff <= rd_v_ff;
         acc_v_ff <= sq_v_ff;
         if (accept && req_data.mode == MODE_CLEAR) begin
            front_count_ff <= '0;
            sum_ff <= '0;
            pop_ff <= '0;
         end
         if (accept && req_data.mode == MODE_LOAD && front_count_ff != CW'(FRONT_DEPTH)) begin
            front_count_ff <= front_count_ff + 1'b1;
         end
         if (accept) begin
            have_ff <= 1'b0;
         end else if (acc_v_ff) begin
            have_ff <= 1'b1;
         end
         if (state_ff == ST_SQRT && sqrt_done && pop_ff < PW'(MAX_POPULATION)) begin
            sum_ff <= sum_ff + SUM_W'(root);
            pop_ff <= pop_ff + 1'b1;
         end
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      result_ff <= result_in;
      if (accept) begin
         scan_addr_ff <= '0;
         for (int i = 0; i < MAX_DIMENSIONS; i++) begin
            pt_ff[i] <= req_coords[i];
         end
      end else if (state_ff == ST_SCAN) begin
         scan_addr_ff <= scan_addr_ff + 1'b1;
      end
      if (accept && req_data.mode == MODE_LOAD && front_count_ff != CW'(FRONT_DEPTH)) begin
         front_mem[front_count_ff[AW-1:0]] <= row_in;
      end
      rd_row_ff <= front_mem[scan_addr_ff];
      acc_ff <= acc_in;
      if (acc_v_ff && (!have_ff || acc_ff < best_ff)) begin
         best_ff <= acc_ff;
      end
      if (state_ff == ST_OUT && out_free) begin
         rsp_data_ff <= result_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule
